// ===== rtl/wsfd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsfd_pkg
// Shared types and constants for the WebSocket frame deframer.
// ----------------------------------------------------------------------------
package wsfd_pkg;

	localparam logic [6:0] LEN_EXT16   = 7'd126;
	localparam logic [6:0] LEN_EXT64   = 7'd127;
	localparam logic [3:0] EXT16_BYTES = 4'd2;
	localparam logic [3:0] EXT64_BYTES = 4'd8;
	localparam logic [2:0] KEY_BYTES   = 3'd4;
	localparam logic [3:0] OP_CLOSE    = 4'h8;

	localparam logic KIND_HEADER  = 1'b0;
	localparam logic KIND_PAYLOAD = 1'b1;

	localparam int CMD_DEPTH = 4;
	localparam int OUT_DEPTH = 2;

	typedef enum logic [2:0] {
		PH_HDR0,
		PH_HDR1,
		PH_EXT,
		PH_KEY,
		PH_DATA
	} phase_t;

	// Item handed from the header parser to the payload unit.
	typedef struct packed {
		logic        kind;
		logic        fin;
		logic [2:0]  rsv;
		logic [3:0]  opcode;
		logic        masked;
		logic [63:0] payload_length;
		logic [7:0]  raw_byte;
		logic [31:0] key;
		logic        last;
	} cmd_t;

	// Result item as seen on the output ports.
	typedef struct packed {
		logic        kind;
		logic        fin;
		logic [2:0]  rsv;
		logic [3:0]  opcode;
		logic        masked;
		logic [63:0] payload_length;
		logic [7:0]  data_byte;
		logic [15:0] close_status;
		logic        last;
	} res_t;

endpackage

// ===== rtl/wsfd_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsfd_fifo
// Small first-in first-out queue with registered count and full flag.
// ----------------------------------------------------------------------------
module wsfd_fifo #(
	parameter int Width = 8,
	parameter int Depth = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [Width-1:0] wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic [Width-1:0] rd_data,
	output logic             empty
);

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);
	localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
	localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

	logic [Width-1:0] mem_q [Depth];
	logic [PtrW-1:0]  wptr_q;
	logic [PtrW-1:0]  rptr_q;
	logic [CntW-1:0]  count_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (count_q == FullCnt);
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= (wptr_q == LastPtr) ? '0 : wptr_q + 1'b1;
			end
			if (do_rd) begin
				rptr_q <= (rptr_q == LastPtr) ? '0 : rptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(full && !do_rd) |=> full)
		else $error("fifo lost an entry while full");

	assert property (@(posedge clk) disable iff (!arst_n)
		(empty && !do_wr) |=> empty)
		else $error("fifo produced an entry from nothing");

	assert property (@(posedge clk) disable iff (!arst_n)
		!(full && empty))
		else $error("fifo full and empty together");

endmodule

// ===== rtl/wsfd_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsfd_front
// Header parser: walks the frame header byte by byte and queues one command
// per header completion and per payload byte.
// ----------------------------------------------------------------------------
module wsfd_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            take,
	input  logic [7:0]      rx_byte,
	output logic            cmd_push,
	output wsfd_pkg::cmd_t  cmd
);

	wsfd_pkg::phase_t phase_q, phase_d;

	logic [7:0]  fb_q, fb_d;
	logic        mask_q, mask_d;
	logic [3:0]  ext_left_q, ext_left_d;
	logic [63:0] len_q, len_d;
	logic [31:0] key_q, key_d;
	logic [2:0]  key_left_q, key_left_d;
	logic [63:0] pay_left_q, pay_left_d;

	logic [6:0]  len7;
	logic        len_is_ext;
	logic [63:0] ext_len;
	logic        emit_hdr;
	logic        emit_data;

	assign len7       = rx_byte[6:0];
	assign len_is_ext = (len7 == wsfd_pkg::LEN_EXT16) || (len7 == wsfd_pkg::LEN_EXT64);
	assign ext_len    = {len_q[55:0], rx_byte};

	// next state
	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			wsfd_pkg::PH_HDR0: begin
				phase_d = wsfd_pkg::PH_HDR1;
			end
			wsfd_pkg::PH_HDR1: begin
				if (len_is_ext) begin
					phase_d = wsfd_pkg::PH_EXT;
				end else if (rx_byte[7]) begin
					phase_d = wsfd_pkg::PH_KEY;
				end else if (len7 == '0) begin
					phase_d = wsfd_pkg::PH_HDR0;
				end else begin
					phase_d = wsfd_pkg::PH_DATA;
				end
			end
			wsfd_pkg::PH_EXT: begin
				if (ext_left_q == 4'd1) begin
					if (mask_q) begin
						phase_d = wsfd_pkg::PH_KEY;
					end else if (ext_len == '0) begin
						phase_d = wsfd_pkg::PH_HDR0;
					end else begin
						phase_d = wsfd_pkg::PH_DATA;
					end
				end
			end
			wsfd_pkg::PH_KEY: begin
				if (key_left_q == 3'd1) begin
					phase_d = (len_q == '0) ? wsfd_pkg::PH_HDR0 : wsfd_pkg::PH_DATA;
				end
			end
			wsfd_pkg::PH_DATA: begin
				if (pay_left_q == 64'd1) begin
					phase_d = wsfd_pkg::PH_HDR0;
				end
			end
			default: begin
				phase_d = wsfd_pkg::PH_HDR0;
			end
		endcase
	end

	// outputs and header registers
	always_comb begin
		fb_d       = fb_q;
		mask_d     = mask_q;
		ext_left_d = ext_left_q;
		len_d      = len_q;
		key_d      = key_q;
		key_left_d = key_left_q;
		pay_left_d = pay_left_q;
		emit_hdr   = 1'b0;
		emit_data  = 1'b0;
		unique case (phase_q)
			wsfd_pkg::PH_HDR0: begin
				fb_d = rx_byte;
			end
			wsfd_pkg::PH_HDR1: begin
				mask_d = rx_byte[7];
				if (len_is_ext) begin
					len_d      = '0;
					ext_left_d = (len7 == wsfd_pkg::LEN_EXT16) ? wsfd_pkg::EXT16_BYTES
					                                           : wsfd_pkg::EXT64_BYTES;
				end else begin
					len_d = {57'd0, len7};
					key_d = '0;
					if (rx_byte[7]) begin
						key_left_d = wsfd_pkg::KEY_BYTES;
					end else begin
						emit_hdr = 1'b1;
					end
				end
			end
			wsfd_pkg::PH_EXT: begin
				len_d      = ext_len;
				ext_left_d = ext_left_q - 1'b1;
				if (ext_left_q == 4'd1) begin
					key_d = '0;
					if (mask_q) begin
						key_left_d = wsfd_pkg::KEY_BYTES;
					end else begin
						emit_hdr = 1'b1;
					end
				end
			end
			wsfd_pkg::PH_KEY: begin
				key_d      = {key_q[23:0], rx_byte};
				key_left_d = key_left_q - 1'b1;
				if (key_left_q == 3'd1) begin
					emit_hdr = 1'b1;
				end
			end
			wsfd_pkg::PH_DATA: begin
				emit_data  = 1'b1;
				pay_left_d = pay_left_q - 1'b1;
			end
			default: begin
			end
		endcase
		if (emit_hdr) begin
			pay_left_d = len_d;
		end
	end

	assign cmd_push           = take && (emit_hdr || emit_data);
	assign cmd.kind           = emit_data ? wsfd_pkg::KIND_PAYLOAD : wsfd_pkg::KIND_HEADER;
	assign cmd.fin            = fb_q[7];
	assign cmd.rsv            = fb_q[6:4];
	assign cmd.opcode         = fb_q[3:0];
	assign cmd.masked         = mask_d;
	assign cmd.payload_length = len_d;
	assign cmd.raw_byte       = rx_byte;
	assign cmd.key            = key_d;
	assign cmd.last           = emit_data ? (pay_left_q == 64'd1) : (len_d == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= wsfd_pkg::PH_HDR0;
			fb_q       <= '0;
			mask_q     <= 1'b0;
			ext_left_q <= '0;
			len_q      <= '0;
			key_q      <= '0;
			key_left_q <= '0;
			pay_left_q <= '0;
		end else if (take) begin
			phase_q    <= phase_d;
			fb_q       <= fb_d;
			mask_q     <= mask_d;
			ext_left_q <= ext_left_d;
			len_q      <= len_d;
			key_q      <= key_d;
			key_left_q <= key_left_d;
			pay_left_q <= pay_left_d;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == wsfd_pkg::PH_KEY) |-> (mask_q && key_left_q != '0))
		else $error("key phase without mask or key count");

	assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == wsfd_pkg::PH_EXT) |-> (ext_left_q != '0))
		else $error("extended length phase with no bytes left");

	assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == wsfd_pkg::PH_DATA) |-> (pay_left_q != '0))
		else $error("payload phase with zero bytes left");

	assert property (@(posedge clk) disable iff (!arst_n)
		(take && phase_q == wsfd_pkg::PH_HDR0) |-> !cmd_push)
		else $error("first header byte produced an item");

endmodule

// ===== rtl/wsfd_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsfd_back
// Payload unit: unmasks payload bytes, collects the close code and forms
// the result items.
// ----------------------------------------------------------------------------
module wsfd_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cmd_valid,
	input  wsfd_pkg::cmd_t  cmd,
	output logic            cmd_pop,
	input  logic            res_full,
	output logic            res_push,
	output wsfd_pkg::res_t  res
);

	logic [31:0] key_q;
	logic [1:0]  kidx_q;
	logic [15:0] close_q, close_d;
	logic [1:0]  cseen_q, cseen_d;
	logic [7:0]  key_byte;
	logic [7:0]  data;
	logic        is_data;

	assign cmd_pop  = cmd_valid && !res_full;
	assign res_push = cmd_pop;
	assign is_data  = (cmd.kind == wsfd_pkg::KIND_PAYLOAD);

	always_comb begin
		case (kidx_q)
			2'd0:    key_byte = key_q[31:24];
			2'd1:    key_byte = key_q[23:16];
			2'd2:    key_byte = key_q[15:8];
			default: key_byte = key_q[7:0];
		endcase
	end

	// key is zero on unmasked frames, so the XOR passes the byte through
	assign data = cmd.raw_byte ^ key_byte;

	always_comb begin
		close_d = close_q;
		cseen_d = cseen_q;
		if (cseen_q < 2'd2) begin
			close_d = {close_q[7:0], data};
			cseen_d = cseen_q + 1'b1;
		end
	end

	assign res.kind           = cmd.kind;
	assign res.fin            = cmd.fin;
	assign res.rsv            = cmd.rsv;
	assign res.opcode         = cmd.opcode;
	assign res.masked         = cmd.masked;
	assign res.payload_length = cmd.payload_length;
	assign res.data_byte      = is_data ? data : '0;
	assign res.last           = cmd.last;
	assign res.close_status   = (is_data && cmd.last && cmd.opcode == wsfd_pkg::OP_CLOSE
	                             && cseen_d == 2'd2) ? close_d : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q   <= '0;
			kidx_q  <= '0;
			close_q <= '0;
			cseen_q <= '0;
		end else if (cmd_pop) begin
			if (is_data) begin
				kidx_q  <= kidx_q + 1'b1;
				close_q <= close_d;
				cseen_q <= cseen_d;
			end else begin
				key_q   <= cmd.key;
				kidx_q  <= '0;
				close_q <= '0;
				cseen_q <= '0;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_pop && !is_data) |=> (kidx_q == '0 && cseen_q == '0))
		else $error("header item did not restart payload state");

	assert property (@(posedge clk) disable iff (!arst_n)
		cseen_q != 2'd3)
		else $error("close byte count overflow");

	assert property (@(posedge clk) disable iff (!arst_n)
		(res.close_status != '0) |-> (is_data && cmd.last))
		else $error("close code outside the last payload item");

	assert property (@(posedge clk) disable iff (!arst_n)
		res_full |-> !res_push)
		else $error("result pushed into a full queue");

endmodule

// ===== rtl/websocket_frame_deframer_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// websocket_frame_deframer_core
// WebSocket frame decoder: header parse, payload unmasking, close code.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive rx_byte and raise push; the byte is taken on a
//   rising edge with push high and full low. One byte per cycle is accepted while full is low.
//   Result channel: while empty is low the oldest result sits on the output
//   ports; raise pop to take it. A header result (kind 0) follows the byte
//   that completes the header; each payload byte gives one result (kind 1).
//   Path: a byte that yields a result is written into the command queue at
//   the accepting edge; the payload unit then moves the item into the
//   result queue once it has room, and the result queue drives the ports.
//   Throughput: one byte per cycle while full is low, set by the single-byte
//   header parser and the one-item-per-cycle payload unit.
//   Stall: when pop stays low the result queue fills, the payload unit
//   halts, then the command queue fills and full rises; no item is lost.
//   Reset: arst_n clears both queues and the parser, which then waits for
//   the first header byte of a frame.
// ----------------------------------------------------------------------------
module websocket_frame_deframer_core #(
	parameter int CMD_DEPTH = wsfd_pkg::CMD_DEPTH,
	parameter int OUT_DEPTH = wsfd_pkg::OUT_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  rx_byte,
	output logic        empty,
	input  logic        pop,
	output logic        kind,
	output logic        fin,
	output logic [2:0]  rsv,
	output logic [3:0]  opcode,
	output logic        masked,
	output logic [63:0] payload_length,
	output logic [7:0]  data_byte,
	output logic [15:0] close_status,
	output logic        last
);

	localparam int CmdW = $bits(wsfd_pkg::cmd_t);
	localparam int ResW = $bits(wsfd_pkg::res_t);

	wsfd_pkg::cmd_t cmd_in, cmd_out;
	wsfd_pkg::res_t res_in, res_out;
	logic [CmdW-1:0] cmd_out_bits;
	logic [ResW-1:0] res_out_bits;
	logic            take;
	logic            cmd_push;
	logic            cmd_empty;
	logic            cmd_pop;
	logic            res_full;
	logic            res_push;

	assign take = push && !full;

	wsfd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (take),
		.rx_byte  (rx_byte),
		.cmd_push (cmd_push),
		.cmd      (cmd_in)
	);

	wsfd_fifo #(
		.Width (CmdW),
		.Depth (CMD_DEPTH)
	) u_cmd_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cmd_push),
		.wr_data (cmd_in),
		.full    (full),
		.rd_en   (cmd_pop),
		.rd_data (cmd_out_bits),
		.empty   (cmd_empty)
	);

	assign cmd_out = cmd_out_bits;

	wsfd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (!cmd_empty),
		.cmd       (cmd_out),
		.cmd_pop   (cmd_pop),
		.res_full  (res_full),
		.res_push  (res_push),
		.res       (res_in)
	);

	wsfd_fifo #(
		.Width (ResW),
		.Depth (OUT_DEPTH)
	) u_res_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_push),
		.wr_data (res_in),
		.full    (res_full),
		.rd_en   (pop),
		.rd_data (res_out_bits),
		.empty   (empty)
	);

	assign res_out        = res_out_bits;
	assign kind           = res_out.kind;
	assign fin            = res_out.fin;
	assign rsv            = res_out.rsv;
	assign opcode         = res_out.opcode;
	assign masked         = res_out.masked;
	assign payload_length = res_out.payload_length;
	assign data_byte      = res_out.data_byte;
	assign close_status   = res_out.close_status;
	assign last           = res_out.last;

endmodule
